// ===== hw/rtl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, codes and types of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int MAX_BLOCKS      = 1024;
  localparam int MAX_BLOCK_BYTES = 65536;

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int LINK_W  = IDX_W + 1;
  localparam int SIZE_W  = 17;
  localparam int OFF_W   = 26;
  localparam int CNT_W   = 11;
  localparam int OOM_W   = 32;
  localparam int STAT_W  = 3;
  localparam int OP_W    = 2;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 17;

  localparam logic [LINK_W-1:0] LINK_NONE  = LINK_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [SIZE_W-1:0] BSIZE_MAX  = SIZE_W'(MAX_BLOCK_BYTES);

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_PRESS = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERSZ  = 3'd2;
  localparam logic [STAT_W-1:0] ST_OOM     = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADPTR  = 3'd4;

  localparam logic [CIDX_W-1:0] REG_BSIZE  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ARENA  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_THRESH = 2'd2;

  localparam logic [SIZE_W-1:0] RST_BSIZE  = 17'd256;
  localparam logic [CNT_W-1:0]  RST_ARENA  = 11'd1024;
  localparam logic [SIZE_W-1:0] RST_THRESH = 17'd52429;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] link_wdata;
    logic [SIZE_W-1:0] size_wdata;
  } store_req_t;

endpackage

// ===== hw/rtl/fbpa_div.sv =====
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring divider, one quotient bit per cycle: offset / block size.
// ----------------------------------------------------------------------------
module fbpa_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fbpa_pkg::OFF_W-1:0]    dividend,
  input  logic [fbpa_pkg::SIZE_W-1:0]   divisor,
  output logic                          done,
  output logic [fbpa_pkg::OFF_W-1:0]    quot,
  output logic [fbpa_pkg::SIZE_W-1:0]   rem
);

  localparam int CW = $clog2(fbpa_pkg::OFF_W + 1);

  logic [fbpa_pkg::OFF_W-1:0]  quo_r, quo_nxt;
  logic [fbpa_pkg::SIZE_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        run_r, run_nxt, done_r, done_nxt;
  logic [fbpa_pkg::SIZE_W:0]   trial;

  always_comb begin
    trial    = {rem_r, quo_r[fbpa_pkg::OFF_W-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(fbpa_pkg::OFF_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = fbpa_pkg::SIZE_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[fbpa_pkg::OFF_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[fbpa_pkg::SIZE_W-1:0];
        quo_nxt = {quo_r[fbpa_pkg::OFF_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/fbpa_store.sv =====
// ----------------------------------------------------------------------------
// fbpa_store
// Per-block link and size memories, one shared read and one write address.
// ----------------------------------------------------------------------------
module fbpa_store (
  input  logic                          clk,
  input  fbpa_pkg::store_req_t          req,
  output logic [fbpa_pkg::LINK_W-1:0]   link_rdata,
  output logic [fbpa_pkg::SIZE_W-1:0]   size_rdata
);

  logic [fbpa_pkg::LINK_W-1:0] link_mem [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::SIZE_W-1:0] size_mem [fbpa_pkg::MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      link_mem[req.wr_addr] <= req.link_wdata;
      size_mem[req.wr_addr] <= req.size_wdata;
    end
    if (req.rd_en) begin
      link_rdata <= link_mem[req.rd_addr];
      size_rdata <= size_mem[req.rd_addr];
    end
  end

endmodule

// ===== hw/rtl/fixed_block_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Fixed-size block pool with a LIFO free list held in block memories.
// ----------------------------------------------------------------------------
// Allocate and pressure test: memory read when the start is accepted, then the
//   update in S_EXEC, which registers the result strobe; busy until that update.
// Free and size query: the 26-step offset divider, the block read, then the update.
// Results appear for one cycle on out_valid; the receiver cannot stall.
// Reset (synchronous, rst_n low) loads the default registers and an empty
//   pool of arena_blocks fresh blocks; block memories need no clearing.
module fixed_block_pool_allocator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [fbpa_pkg::OP_W-1:0]     in_opcode,
  input  logic [fbpa_pkg::SIZE_W-1:0]   in_request_bytes,
  input  logic [fbpa_pkg::OFF_W-1:0]    in_byte_offset,
  output logic                          out_valid,
  output logic [fbpa_pkg::STAT_W-1:0]   out_status,
  output logic [fbpa_pkg::IDX_W-1:0]    out_block_index,
  output logic [fbpa_pkg::OFF_W-1:0]    out_block_offset,
  output logic [fbpa_pkg::SIZE_W-1:0]   out_stored_size,
  output logic                          out_pressure_high,
  output logic [fbpa_pkg::CNT_W-1:0]    out_free_blocks,
  output logic [fbpa_pkg::OOM_W-1:0]    out_oom_events,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fbpa_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [fbpa_pkg::CDATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  localparam int PROD_W = fbpa_pkg::IDX_W + fbpa_pkg::SIZE_W;
  localparam int PW     = fbpa_pkg::SIZE_W + fbpa_pkg::CNT_W;

  state_t state_r, state_nxt;

  // configuration registers
  logic [fbpa_pkg::SIZE_W-1:0] bsize_r, thresh_r;
  logic [fbpa_pkg::CNT_W-1:0]  arena_r;

  // pool state
  logic [fbpa_pkg::LINK_W-1:0] head_r, head_nxt;
  logic [fbpa_pkg::CNT_W-1:0]  fresh_r, fresh_nxt;
  logic [fbpa_pkg::CNT_W-1:0]  free_r, free_nxt;
  logic [fbpa_pkg::CNT_W-1:0]  used_r, used_nxt;
  logic [fbpa_pkg::OOM_W-1:0]  oom_r, oom_nxt;

  // item under work
  logic [fbpa_pkg::OP_W-1:0]   op_r;
  logic [fbpa_pkg::SIZE_W-1:0] req_r;
  logic [fbpa_pkg::IDX_W-1:0]  qidx_r;
  logic                        bad_r;

  // result word
  logic                        ov_r, ov_nxt;
  logic [fbpa_pkg::STAT_W-1:0] st_r, st_nxt;
  logic [fbpa_pkg::IDX_W-1:0]  bi_r, bi_nxt;
  logic [fbpa_pkg::OFF_W-1:0]  bo_r, bo_nxt;
  logic [fbpa_pkg::SIZE_W-1:0] ss_r, ss_nxt;
  logic                        ph_r, ph_nxt;

  logic                        accept, cfg_we;
  logic [fbpa_pkg::CNT_W-1:0]  nb, nb_cfg;
  logic [fbpa_pkg::SIZE_W-1:0] bs;
  logic [fbpa_pkg::IDX_W-1:0]  aidx;
  logic [PROD_W-1:0]           boff_prod;
  logic [PW-1:0]               press_lhs, press_rhs;
  logic                        avail;

  fbpa_pkg::store_req_t        sreq;
  logic [fbpa_pkg::LINK_W-1:0] link_rdata;
  logic [fbpa_pkg::SIZE_W-1:0] size_rdata;

  logic                        div_done;
  logic [fbpa_pkg::OFF_W-1:0]  div_quot;
  logic [fbpa_pkg::SIZE_W-1:0] div_rem;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  // hold register writes off while a command word is being taken
  assign cfg_ready = !busy && !start;
  assign cfg_we    = cfg_valid && cfg_ready;

  // effective pool size and block size
  assign nb = (arena_r > fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS))
            ? fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS) : arena_r;
  assign nb_cfg = (cfg_data[fbpa_pkg::CNT_W-1:0] > fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS))
                ? fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS) : cfg_data[fbpa_pkg::CNT_W-1:0];
  assign bs = (bsize_r == '0) ? fbpa_pkg::SIZE_W'(1)
            : ((bsize_r > fbpa_pkg::BSIZE_MAX) ? fbpa_pkg::BSIZE_MAX : bsize_r);

  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && (in_opcode == fbpa_pkg::OP_FREE || in_opcode == fbpa_pkg::OP_QUERY)),
    .dividend (in_byte_offset),
    .divisor  (bs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  fbpa_store u_store (
    .clk        (clk),
    .req        (sreq),
    .link_rdata (link_rdata),
    .size_rdata (size_rdata)
  );

  assign avail     = (head_r < fbpa_pkg::LINK_NONE) || (fresh_r < nb);
  assign aidx      = (head_r < fbpa_pkg::LINK_NONE) ? head_r[fbpa_pkg::IDX_W-1:0]
                                                    : fresh_r[fbpa_pkg::IDX_W-1:0];
  assign boff_prod = aidx * bs;
  assign press_lhs = PW'({(fbpa_pkg::CNT_W+1)'(used_r) + 1'b1, 16'h0000});
  assign press_rhs = thresh_r * nb;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    fresh_nxt = fresh_r;
    free_nxt  = free_r;
    used_nxt  = used_r;
    oom_nxt   = oom_r;
    ov_nxt    = 1'b0;
    st_nxt    = fbpa_pkg::ST_OK;
    bi_nxt    = '0;
    bo_nxt    = '0;
    ss_nxt    = '0;
    ph_nxt    = 1'b0;

    // read the head link on accept, or the addressed block after the divide
    sreq.rd_en      = 1'b0;
    sreq.rd_addr    = head_r[fbpa_pkg::IDX_W-1:0];
    sreq.wr_en      = 1'b0;
    sreq.wr_addr    = aidx;
    sreq.link_wdata = fbpa_pkg::LINK_NONE;
    sreq.size_wdata = req_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          sreq.rd_en = 1'b1;
          if (in_opcode == fbpa_pkg::OP_FREE || in_opcode == fbpa_pkg::OP_QUERY) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          sreq.rd_en   = 1'b1;
          sreq.rd_addr = div_quot[fbpa_pkg::IDX_W-1:0];
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        unique case (op_r)
          fbpa_pkg::OP_ALLOC: begin
            if (req_r == '0 || nb == '0) begin
              st_nxt = fbpa_pkg::ST_NULL;
            end else if (!avail || free_r == '0) begin
              st_nxt  = fbpa_pkg::ST_OOM;
              oom_nxt = oom_r + 1'b1;
            end else if (req_r > bs) begin
              st_nxt = fbpa_pkg::ST_OVERSZ;
            end else begin
              // pop the free list, else take the next fresh block
              if (head_r < fbpa_pkg::LINK_NONE) begin
                head_nxt = (link_rdata > fbpa_pkg::LINK_NONE) ? fbpa_pkg::LINK_NONE
                                                              : link_rdata;
              end else begin
                fresh_nxt = fresh_r + 1'b1;
              end
              sreq.wr_en = 1'b1;
              if (used_r < fbpa_pkg::COUNT_MAX) begin
                used_nxt = used_r + 1'b1;
              end
              free_nxt = free_r - 1'b1;
              bi_nxt   = aidx;
              bo_nxt   = boff_prod[fbpa_pkg::OFF_W-1:0];
            end
          end
          fbpa_pkg::OP_FREE,
          fbpa_pkg::OP_QUERY: begin
            if (bad_r) begin
              st_nxt = fbpa_pkg::ST_BADPTR;
            end else begin
              bi_nxt = qidx_r;
              ss_nxt = size_rdata;
              if (op_r == fbpa_pkg::OP_FREE) begin
                // push the block, clear its recorded size
                if (used_r != '0) begin
                  used_nxt = used_r - 1'b1;
                end
                if (free_r < fbpa_pkg::COUNT_MAX) begin
                  free_nxt = free_r + 1'b1;
                end
                sreq.wr_en      = 1'b1;
                sreq.wr_addr    = qidx_r;
                sreq.link_wdata = head_r;
                sreq.size_wdata = '0;
                head_nxt        = {1'b0, qidx_r};
              end
            end
          end
          fbpa_pkg::OP_PRESS: begin
            if (req_r == '0 || nb == '0) begin
              st_nxt = fbpa_pkg::ST_NULL;
            end else if (req_r > bs) begin
              st_nxt = fbpa_pkg::ST_OVERSZ;
            end else begin
              ph_nxt = (press_lhs > press_rhs);
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase

    // rewriting the block count restarts the pool
    if (cfg_we && cfg_index == fbpa_pkg::REG_ARENA) begin
      head_nxt  = fbpa_pkg::LINK_NONE;
      fresh_nxt = '0;
      used_nxt  = '0;
      free_nxt  = nb_cfg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      bsize_r  <= fbpa_pkg::RST_BSIZE;
      arena_r  <= fbpa_pkg::RST_ARENA;
      thresh_r <= fbpa_pkg::RST_THRESH;
      head_r   <= fbpa_pkg::LINK_NONE;
      fresh_r  <= '0;
      free_r   <= fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS);
      used_r   <= '0;
      oom_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fresh_r <= fresh_nxt;
      free_r  <= free_nxt;
      used_r  <= used_nxt;
      oom_r   <= oom_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          fbpa_pkg::REG_BSIZE:  bsize_r  <= cfg_data;
          fbpa_pkg::REG_ARENA:  arena_r  <= cfg_data[fbpa_pkg::CNT_W-1:0];
          fbpa_pkg::REG_THRESH: thresh_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      req_r <= in_request_bytes;
    end
    if (state_r == S_DIV && div_done) begin
      qidx_r <= div_quot[fbpa_pkg::IDX_W-1:0];
      bad_r  <= (div_quot >= fbpa_pkg::OFF_W'(nb)) || (div_rem != '0);
    end
    if (ov_nxt) begin
      st_r <= st_nxt;
      bi_r <= bi_nxt;
      bo_r <= bo_nxt;
      ss_r <= ss_nxt;
      ph_r <= ph_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = st_r;
  assign out_block_index   = bi_r;
  assign out_block_offset  = bo_r;
  assign out_stored_size   = ss_r;
  assign out_pressure_high = ph_r;
  assign out_free_blocks   = free_r;
  assign out_oom_events    = oom_r;

endmodule

// ===== hw/rtl/fbpa_checker.sv =====
// ----------------------------------------------------------------------------
// fbpa_port_checks
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbpa_port_checks (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [fbpa_pkg::STAT_W-1:0]   out_status,
  input logic [fbpa_pkg::IDX_W-1:0]    out_block_index,
  input logic [fbpa_pkg::OFF_W-1:0]    out_block_offset,
  input logic                          out_pressure_high,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_err_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != fbpa_pkg::ST_OK |-> out_block_offset == '0)
    else $error("offset on failed operation");

  a_null_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == fbpa_pkg::ST_NULL
      |-> !out_pressure_high && out_block_index == '0)
    else $error("null result carries data");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !busy)
    else $error("config taken while busy");

endmodule

bind fixed_block_pool_allocator_unit fbpa_port_checks u_fbpa_port_checks (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_block_index   (out_block_index),
  .out_block_offset  (out_block_offset),
  .out_pressure_high (out_pressure_high),
  .cfg_valid         (cfg_valid),
  .cfg_ready         (cfg_ready)
);
